>>> design/modulated_iir_notch_filter_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the modulated IIR notch filter
// Implication and next-cycle implication checks, empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef MODULATED_IIR_NOTCH_FILTER_TOP_ASSERT_SVH
`define MODULATED_IIR_NOTCH_FILTER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define MINF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("minf: same-cycle check failed");
`define MINF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("minf: next-cycle check failed");
`else
`define MINF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MINF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> design/minf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minf_pkg
// Shared widths, constants, item types and the CORDIC angle table.
// ----------------------------------------------------------------------------
package minf_pkg;

	localparam int CHANNELS_DEF = 2;
	localparam int TAPS         = 5;
	localparam int NTERMS       = 2 * TAPS + 1;
	localparam int CORDIC_STEPS = 24;
	localparam int PI_Q16       = 205887;
	localparam int FS_W         = 18;
	localparam int FS_RESET     = 48000;
	localparam int SAMPLE_W     = 24;
	localparam int FREQ_W       = 17;
	localparam int DAMP_W       = 16;
	localparam int CX_W         = 40;
	localparam int Z_W          = 27;
	localparam int U_W          = Z_W - 1;
	localparam int COEF_W       = 36;
	localparam int PROD_W       = COEF_W + SAMPLE_W;
	localparam int ACC_W        = 64;
	localparam int QDEPTH       = 2;

	typedef struct packed {
		logic                       channel;
		logic signed [SAMPLE_W-1:0] sample_in;
		logic [FREQ_W-1:0]          notch_freq_hz;
		logic [DAMP_W-1:0]          damping;
	} in_item_t;

	typedef struct packed {
		logic                       out_channel;
		logic signed [SAMPLE_W-1:0] sample_out;
	} out_item_t;

	// work handed from the prewarp front end to the filter back end
	typedef struct packed {
		logic                       chan;
		logic signed [SAMPLE_W-1:0] x;
		logic [DAMP_W-1:0]          d;
		logic [U_W-1:0]             u;
	} job_t;

	// atan(2^-i) in radians, Q24
	function automatic logic signed [Z_W-1:0] atan_q24(input logic [4:0] i);
		logic [Z_W-1:0] v;
		case (i)
			5'd0:  v = Z_W'(13176795);
			5'd1:  v = Z_W'(7778716);
			5'd2:  v = Z_W'(4110060);
			5'd3:  v = Z_W'(2086331);
			5'd4:  v = Z_W'(1047214);
			5'd5:  v = Z_W'(524117);
			5'd6:  v = Z_W'(262123);
			5'd7:  v = Z_W'(131069);
			5'd8:  v = Z_W'(65536);
			5'd9:  v = Z_W'(32768);
			5'd10: v = Z_W'(16384);
			5'd11: v = Z_W'(8192);
			5'd12: v = Z_W'(4096);
			5'd13: v = Z_W'(2048);
			5'd14: v = Z_W'(1024);
			5'd15: v = Z_W'(512);
			5'd16: v = Z_W'(256);
			5'd17: v = Z_W'(128);
			5'd18: v = Z_W'(64);
			5'd19: v = Z_W'(32);
			5'd20: v = Z_W'(16);
			5'd21: v = Z_W'(8);
			5'd22: v = Z_W'(4);
			5'd23: v = Z_W'(2);
			default: v = '0;
		endcase
		return signed'(v);
	endfunction

endpackage

>>> design/minf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minf_queue
// Short register queue of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module minf_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  minf_pkg::job_t     din,
	output logic               full,
	input  logic               pop,
	output minf_pkg::job_t     dout,
	output logic               empty
);
	localparam int PTR_W = $clog2(minf_pkg::QDEPTH);
	localparam int CNT_W = $clog2(minf_pkg::QDEPTH + 1);

	minf_pkg::job_t   mem_q [minf_pkg::QDEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(minf_pkg::QDEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(minf_pkg::QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_W'(minf_pkg::QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

>>> design/minf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minf_front
// Accepts items and prewarps the notch frequency with a vectoring CORDIC.
// ----------------------------------------------------------------------------
module minf_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [minf_pkg::FS_W-1:0]   sample_rate,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  minf_pkg::in_item_t          in_item,
	output logic                        push,
	input  logic                        full,
	output minf_pkg::job_t              job
);
	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_ROT  = 3'b010,
		F_PUSH = 3'b100
	} fstate_t;

	localparam int FP_W = minf_pkg::FREQ_W + minf_pkg::FS_W;

	fstate_t                            state_q;
	logic [4:0]                         step_q;
	logic signed [minf_pkg::CX_W-1:0]   cx_q, cy_q, dx, dy;
	logic signed [minf_pkg::Z_W-1:0]    cz_q, ang;
	logic                               chan_q;
	logic signed [minf_pkg::SAMPLE_W-1:0] x_q;
	logic [minf_pkg::DAMP_W-1:0]        d_q;
	logic [FP_W-1:0]                    fy;
	logic                               y_pos;

	assign in_ready = (state_q == F_IDLE);
	assign push     = (state_q == F_PUSH) && !full;
	assign fy       = FP_W'(in_item.notch_freq_hz) * FP_W'(minf_pkg::PI_Q16);
	assign dx       = cy_q >>> step_q;
	assign dy       = cx_q >>> step_q;
	assign ang      = minf_pkg::atan_q24(step_q);
	assign y_pos    = !cy_q[minf_pkg::CX_W-1] && (cy_q != '0);

	// clamp the angle at zero and double it
	always_comb begin
		job.chan = chan_q;
		job.x    = x_q;
		job.d    = d_q;
		job.u    = cz_q[minf_pkg::Z_W-1] ? '0 : {cz_q[minf_pkg::U_W-2:0], 1'b0};
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			chan_q <= in_item.channel;
			x_q    <= in_item.sample_in;
			d_q    <= in_item.damping;
			cx_q   <= signed'({(minf_pkg::CX_W - minf_pkg::FS_W - 16)'(0), sample_rate, 16'b0});
			cy_q   <= signed'(minf_pkg::CX_W'(fy));
			cz_q   <= '0;
		end else if (state_q == F_ROT) begin
			if (y_pos) begin
				cx_q <= cx_q + dx;
				cy_q <= cy_q - dy;
				cz_q <= cz_q + ang;
			end else begin
				cx_q <= cx_q - dx;
				cy_q <= cy_q + dy;
				cz_q <= cz_q - ang;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					step_q <= '0;
					if (in_valid) begin
						state_q <= F_ROT;
					end
				end
				F_ROT: begin
					step_q <= step_q + 1'b1;
					if (step_q == 5'(minf_pkg::CORDIC_STEPS - 1)) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end
endmodule

>>> design/minf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minf_back
// Coefficients, fifth-order recursion, division by a0 and channel histories.
// ----------------------------------------------------------------------------
module minf_back #(
	parameter int CHANNELS = minf_pkg::CHANNELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               empty,
	input  minf_pkg::job_t     job,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output minf_pkg::out_item_t out_item
);
	typedef enum logic [9:0] {
		B_IDLE = 10'b0000000001,
		B_MUL  = 10'b0000000010,
		B_COEF = 10'b0000000100,
		B_MAC  = 10'b0000001000,
		B_ABS  = 10'b0000010000,
		B_RND  = 10'b0000100000,
		B_CHK  = 10'b0001000000,
		B_DIV  = 10'b0010000000,
		B_FIN  = 10'b0100000000,
		B_OUT  = 10'b1000000000
	} bstate_t;

	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SW     = minf_pkg::SAMPLE_W;
	localparam int CW     = minf_pkg::COEF_W;
	localparam int UW     = minf_pkg::U_W;
	localparam int U2P_W  = 2 * UW;
	localparam int DUP_W  = UW + minf_pkg::DAMP_W;
	localparam int T_W    = 29;
	localparam int AW     = minf_pkg::ACC_W;
	localparam logic signed [CW-1:0] FOUR  = CW'(64'sd67108864);
	localparam logic signed [CW-1:0] EIGHT = CW'(64'sd134217728);
	localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

	bstate_t                 state_q;
	logic                    chan_q, neg_q, ovf_q, out_valid_q;
	logic [CH_W-1:0]         idx_q;
	logic signed [SW-1:0]    x_q, y_q, oper;
	logic [minf_pkg::DAMP_W-1:0] d_q;
	logic [UW-1:0]           u_q;
	logic [U2P_W-1:0]        u2p_q;
	logic [DUP_W-1:0]        dup_q;
	logic signed [CW-1:0]    coef_q [minf_pkg::NTERMS];
	logic signed [CW-1:0]    u2, du, csel;
	logic [CW-1:0]           den_q;
	logic [3:0]              cnt_q;
	logic [4:0]              step_q;
	logic signed [minf_pkg::PROD_W-1:0] prod_q, prod_d;
	logic signed [AW-1:0]    acc_q;
	logic [AW-1:0]           rem_q, dsh_q;
	logic [SW-1:0]           quo_q;
	logic                    ge;
	logic signed [SW-1:0]    xh_q [CHANNELS][minf_pkg::TAPS];
	logic signed [SW-1:0]    yh_q [CHANNELS][minf_pkg::TAPS];
	logic                    load;

	assign pop       = (state_q == B_IDLE) && !empty;
	assign load      = (state_q == B_OUT) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	// round u^2 to Q24 and u*d to Q24
	assign u2 = signed'(CW'(T_W'((u2p_q + U2P_W'(1 << 23)) >> 24)));
	assign du = signed'(CW'(T_W'((dup_q + DUP_W'(1 << 13)) >> 14)));

	always_comb begin
		case (cnt_q)
			4'd0:    oper = x_q;
			4'd1:    oper = xh_q[idx_q][0];
			4'd2:    oper = xh_q[idx_q][1];
			4'd3:    oper = xh_q[idx_q][2];
			4'd4:    oper = xh_q[idx_q][3];
			4'd5:    oper = xh_q[idx_q][4];
			4'd6:    oper = yh_q[idx_q][0];
			4'd7:    oper = yh_q[idx_q][1];
			4'd8:    oper = yh_q[idx_q][2];
			4'd9:    oper = yh_q[idx_q][3];
			4'd10:   oper = yh_q[idx_q][4];
			default: oper = '0;
		endcase
		csel = (cnt_q < 4'(minf_pkg::NTERMS)) ? coef_q[cnt_q] : '0;
	end

	assign prod_d = csel * oper;
	assign ge     = (rem_q >= dsh_q);

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				chan_q <= job.chan;
				idx_q  <= (CHANNELS == 1) ? '0 : CH_W'(job.chan);
				x_q    <= job.x;
				d_q    <= job.d;
				u_q    <= job.u;
			end
			B_MUL: begin
				u2p_q <= U2P_W'(u_q) * U2P_W'(u_q);
				dup_q <= DUP_W'(u_q) * DUP_W'(d_q);
			end
			B_COEF: begin
				// feedback terms are stored negated so the recursion only adds
				coef_q[0]  <= u2 + FOUR;
				coef_q[1]  <= CW'(5) * u2 + FOUR;
				coef_q[2]  <= CW'(10) * u2 - EIGHT;
				coef_q[3]  <= CW'(10) * u2 - EIGHT;
				coef_q[4]  <= CW'(5) * u2 + FOUR;
				coef_q[5]  <= u2 + FOUR;
				coef_q[6]  <= -(CW'(5) * u2 + CW'(12) * du + FOUR);
				coef_q[7]  <= -(CW'(10) * u2 + CW'(8) * du - EIGHT);
				coef_q[8]  <= -(CW'(10) * u2 - CW'(8) * du - EIGHT);
				coef_q[9]  <= -(CW'(5) * u2 - CW'(12) * du + FOUR);
				coef_q[10] <= -(u2 - CW'(4) * du + FOUR);
				den_q      <= unsigned'(u2 + CW'(4) * du + FOUR);
				acc_q      <= '0;
			end
			B_MAC: begin
				prod_q <= prod_d;
				if (cnt_q != '0) begin
					acc_q <= acc_q + AW'(prod_q);
				end
			end
			B_ABS: begin
				neg_q <= acc_q[AW-1];
				rem_q <= acc_q[AW-1] ? unsigned'(-acc_q) : unsigned'(acc_q);
			end
			B_RND: begin
				rem_q <= rem_q + AW'(den_q >> 1);
				dsh_q <= AW'(den_q) << SW;
			end
			B_CHK: begin
				ovf_q <= ge;
				dsh_q <= dsh_q >> 1;
				quo_q <= '0;
			end
			B_DIV: begin
				if (ge) begin
					rem_q <= rem_q - dsh_q;
				end
				quo_q <= {quo_q[SW-2:0], ge};
				dsh_q <= dsh_q >> 1;
			end
			B_FIN: begin
				if (neg_q) begin
					y_q <= (ovf_q || (quo_q > SW'(unsigned'(S_MIN)))) ? S_MIN :
						SW'(-signed'({1'b0, quo_q}));
				end else begin
					y_q <= (ovf_q || (quo_q > SW'(unsigned'(S_MAX)))) ? S_MAX :
						signed'(quo_q);
				end
			end
			B_OUT: begin
				if (load) begin
					out_item.out_channel <= chan_q;
					out_item.sample_out  <= y_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			cnt_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < CHANNELS; c++) begin
				for (int k = 0; k < minf_pkg::TAPS; k++) begin
					xh_q[c][k] <= '0;
					yh_q[c][k] <= '0;
				end
			end
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				for (int k = minf_pkg::TAPS - 1; k > 0; k--) begin
					xh_q[idx_q][k] <= xh_q[idx_q][k-1];
					yh_q[idx_q][k] <= yh_q[idx_q][k-1];
				end
				xh_q[idx_q][0] <= x_q;
				yh_q[idx_q][0] <= y_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: if (!empty) state_q <= B_MUL;
				B_MUL:  state_q <= B_COEF;
				B_COEF: begin
					cnt_q   <= '0;
					state_q <= B_MAC;
				end
				B_MAC: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 4'(minf_pkg::NTERMS)) begin
						state_q <= B_ABS;
					end
				end
				B_ABS:  state_q <= B_RND;
				B_RND:  state_q <= B_CHK;
				B_CHK: begin
					step_q  <= 5'(SW - 1);
					state_q <= B_DIV;
				end
				B_DIV: begin
					step_q <= step_q - 1'b1;
					if (step_q == '0) begin
						state_q <= B_FIN;
					end
				end
				B_FIN:  state_q <= B_OUT;
				B_OUT:  if (load) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule

>>> design/modulated_iir_notch_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modulated_iir_notch_filter_top
// Per-channel modulated fifth-order IIR notch filter on Q1.23 audio.
// ----------------------------------------------------------------------------
// Each input item carries a channel, a Q1.23 sample, a notch frequency in hertz
// and a Q2.14 damping value; each yields exactly one result item, in order,
// with the filtered sample saturated to 24 bits. A front end takes the item
// and prewarps the frequency with a 24-step CORDIC; a two-entry
// queue hands the job to the back end, which forms the coefficients, runs the
// eleven-term recursion on one multiplier and divides by a0 one quotient bit
// per cycle. The front end works on the next item while the back end is
// busy with the previous one. The sample rate register is written through
// wr_en/wr_data; the user must write it only while no item is in flight, as
// the block does not enforce this. Channel histories are cleared by reset.
`include "modulated_iir_notch_filter_top_assert.svh"
module modulated_iir_notch_filter_top #(
	parameter int CHANNELS = minf_pkg::CHANNELS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [minf_pkg::FS_W-1:0]   wr_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  minf_pkg::in_item_t          in_item,
	output logic                        out_valid,
	input  logic                        out_ready,
	output minf_pkg::out_item_t         out_item
);
	logic [minf_pkg::FS_W-1:0] sample_rate_q;
	logic                      q_push, q_full, q_pop, q_empty;
	minf_pkg::job_t            q_din, q_dout;

	// hold the sample rate; the user must write it only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_rate_q <= minf_pkg::FS_W'(minf_pkg::FS_RESET);
		end else if (wr_en) begin
			sample_rate_q <= wr_data;
		end
	end

	// accept items and prewarp
	minf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_rate (sample_rate_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_item     (in_item),
		.push        (q_push),
		.full        (q_full),
		.job         (q_din)
	);

	// decouple the two ends so each stalls on its own
	minf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	// filter, divide, update history, drive the output register
	minf_back #(
		.CHANNELS (CHANNELS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (q_empty),
		.job       (q_dout),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// never push into a full queue or pop an empty one
	`MINF_ASSERT_IMP(a_push_space, clk, arst_n, q_push, !q_full)
	`MINF_ASSERT_IMP(a_pop_data, clk, arst_n, q_pop, !q_empty)
	// front end is busy for the CORDIC run after taking an item
	`MINF_ASSERT_NXT(a_front_busy, clk, arst_n, in_valid && in_ready, !in_ready)
endmodule
